FILE: hw/rtl/tns_pkg.sv
// Shared types and constants for the top-n shortlist block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package tns_pkg;

  localparam int MAX_SLOTS   = 32;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
  localparam int ID_W        = 32;
  localparam int SCORE_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [ID_W-1:0]           id_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam cnt_t   CAP_RESET = cnt_t'(MAX_SLOTS);

  // Opcode of an input beat.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_EMPTY = 2'd2
  } action_t;

  // Classified request as it waits in the queue.
  typedef struct packed {
    logic   is_remove;
    id_t    id;
    score_t score;
  } item_t;

  typedef struct packed {
    slot_t   slot;
    id_t     slot_id;
    score_t  slot_score;
    action_t action;
    cnt_t    list_size;
    score_t  cutoff;
    logic    last;
  } result_t;

endpackage

FILE: hw/rtl/tns_front.sv
// Input stage of the shortlist: takes beats, decodes the opcode, and
// pushes classified requests into the queue. Depends on tns_pkg.
`timescale 1ns / 1ps

module tns_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [0:0]             in_opcode,
  input  tns_pkg::id_t           in_item_id,
  input  tns_pkg::score_t        in_item_score,
  output logic                   push,
  output tns_pkg::item_t         push_item,
  input  logic                   q_full
);

  logic           f_vld_r, f_vld_nxt;
  tns_pkg::item_t f_item_r;
  logic           accept;

  assign in_stall  = f_vld_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = f_vld_r && !q_full;
  assign push_item = f_item_r;

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (accept) begin
      f_vld_nxt = 1'b1;
    end else if (push) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r.is_remove <= (in_opcode[0] == tns_pkg::OP_REMOVE);
      f_item_r.id        <= in_item_id;
      f_item_r.score     <= in_item_score;
    end
  end

endmodule

FILE: hw/rtl/tns_queue.sv
// Short request queue between the front and the scan engine.
// Depends on tns_pkg for the entry type and depth.
`timescale 1ns / 1ps

module tns_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tns_pkg::item_t push_item,
  output logic           full,
  output logic           q_vld,
  output tns_pkg::item_t q_item,
  input  logic           pop
);

  tns_pkg::item_t                      ent_r [tns_pkg::QUEUE_DEPTH];
  logic [tns_pkg::QPTR_W-1:0]          wr_ptr_r, rd_ptr_r;
  logic [tns_pkg::QPTR_W:0]            cnt_r, cnt_nxt;
  logic                                do_push, do_pop;

  assign full    = (cnt_r == (tns_pkg::QPTR_W+1)'(tns_pkg::QUEUE_DEPTH));
  assign q_vld   = (cnt_r != '0);
  assign q_item  = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_vld;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/tns_back.sv
// Scan engine of the shortlist: slot memories, valid bits, count, cutoff,
// capacity register and the result register. Depends on tns_pkg.
`timescale 1ns / 1ps

module tns_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_vld,
  input  tns_pkg::item_t      q_item,
  output logic                pop,
  input  logic                cfg_wr_en,
  input  tns_pkg::cnt_t       cfg_wr_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tns_pkg::result_t    out_res
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } st_t;

  st_t                          state_r, state_nxt;
  tns_pkg::item_t               op_r, op_nxt;
  tns_pkg::slot_t               cur_r, cur_nxt;
  tns_pkg::cnt_t                cap_r;
  logic [tns_pkg::MAX_SLOTS-1:0] valid_r, valid_nxt;
  tns_pkg::cnt_t                cnt_r, cnt_nxt;
  tns_pkg::score_t              cutoff_r, cutoff_nxt;

  tns_pkg::id_t                 id_mem    [tns_pkg::MAX_SLOTS];
  tns_pkg::score_t              score_mem [tns_pkg::MAX_SLOTS];
  tns_pkg::id_t                 rd_id_r;
  tns_pkg::score_t              rd_score_r;
  logic                         rd_en, wr_en;
  tns_pkg::slot_t               rd_addr, wr_addr;

  logic                         empty_fnd_r, empty_fnd_nxt;
  tns_pkg::slot_t               empty_idx_r, empty_idx_nxt;
  logic                         low_fnd_r, low_fnd_nxt;
  tns_pkg::slot_t               low_idx_r, low_idx_nxt;
  tns_pkg::score_t              low_score_r, low_score_nxt;

  logic                         pend_vld_r, pend_vld_nxt;
  tns_pkg::result_t             pend_r, pend_nxt;
  logic                         out_vld_r, out_vld_nxt;
  tns_pkg::result_t             out_r, out_nxt;

  tns_pkg::cnt_t                cap_m1, cap_eff;
  tns_pkg::slot_t               cap_last;
  logic                         out_free, scan_last, cur_valid, advance;
  logic                         full, have_tgt, tgt_empty;
  tns_pkg::slot_t               tgt;
  tns_pkg::score_t              ins_cutoff;
  tns_pkg::cnt_t                ins_cnt;
  tns_pkg::result_t             none_res;

  assign out_valid = out_vld_r;
  assign out_res   = out_r;
  assign out_free  = !out_vld_r || !out_stall;

  // Effective capacity: zero acts as one, anything above the slot count
  // acts as the slot count.
  assign cap_m1 = cap_r - 1'b1;
  always_comb begin
    if (cap_r == '0) begin
      cap_last = '0;
    end else if (cap_r > tns_pkg::cnt_t'(tns_pkg::MAX_SLOTS)) begin
      cap_last = tns_pkg::slot_t'(tns_pkg::MAX_SLOTS - 1);
    end else begin
      cap_last = cap_m1[tns_pkg::SLOT_W-1:0];
    end
  end
  assign cap_eff = tns_pkg::cnt_t'(cap_last) + 1'b1;

  assign cur_valid = valid_r[cur_r];
  assign scan_last = op_r.is_remove ? (cur_r == tns_pkg::slot_t'(tns_pkg::MAX_SLOTS - 1))
                                    : (cur_r == cap_last);

  // Insert decision, used in the finishing cycle once the scan is done.
  always_comb begin
    full       = (cnt_r >= cap_eff);
    have_tgt   = 1'b0;
    tgt_empty  = 1'b0;
    tgt        = '0;
    ins_cutoff = cutoff_r;
    if (!full) begin
      if ($signed(op_r.score) >= $signed(cutoff_r) && empty_fnd_r) begin
        have_tgt  = 1'b1;
        tgt_empty = 1'b1;
        tgt       = empty_idx_r;
      end
    end else if (empty_fnd_r) begin
      have_tgt  = 1'b1;
      tgt_empty = 1'b1;
      tgt       = empty_idx_r;
    end else if (low_fnd_r && $signed(op_r.score) > $signed(low_score_r)) begin
      have_tgt = 1'b1;
      tgt      = low_idx_r;
      if ($signed(low_score_r) > $signed(cutoff_r)) begin
        ins_cutoff = low_score_r;
      end
    end else if ($signed(op_r.score) > $signed(cutoff_r)) begin
      ins_cutoff = op_r.score;
    end
    ins_cnt = cnt_r;
    if (have_tgt && tgt_empty && cnt_r < tns_pkg::cnt_t'(tns_pkg::MAX_SLOTS)) begin
      ins_cnt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cur_nxt       = cur_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    cutoff_nxt    = cutoff_r;
    empty_fnd_nxt = empty_fnd_r;
    empty_idx_nxt = empty_idx_r;
    low_fnd_nxt   = low_fnd_r;
    low_idx_nxt   = low_idx_r;
    low_score_nxt = low_score_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_vld_nxt   = out_vld_r && out_stall;
    out_nxt       = out_r;
    pop           = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = tgt;
    advance       = 1'b1;

    none_res            = '0;
    none_res.action     = tns_pkg::ACT_NONE;
    none_res.list_size  = cnt_r;
    none_res.cutoff     = cutoff_r;
    none_res.last       = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (q_vld) begin
          pop           = 1'b1;
          op_nxt        = q_item;
          cur_nxt       = '0;
          rd_en         = 1'b1;
          rd_addr       = '0;
          empty_fnd_nxt = 1'b0;
          low_fnd_nxt   = 1'b0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!op_r.is_remove) begin
          if (!cur_valid && !empty_fnd_r) begin
            empty_fnd_nxt = 1'b1;
            empty_idx_nxt = cur_r;
          end
          if (cur_valid && (!low_fnd_r || $signed(rd_score_r) < $signed(low_score_r))) begin
            low_fnd_nxt   = 1'b1;
            low_idx_nxt   = cur_r;
            low_score_nxt = rd_score_r;
          end
        end else if (cur_valid && rd_id_r == op_r.id) begin
          // A match is parked in the pending register until the next match
          // or the end of the scan tells whether it is the final one.
          if (pend_vld_r && !out_free) begin
            advance = 1'b0;
          end else begin
            if (pend_vld_r) begin
              out_vld_nxt = 1'b1;
              out_nxt     = pend_r;
            end
            valid_nxt[cur_r]    = 1'b0;
            cnt_nxt             = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
            pend_vld_nxt        = 1'b1;
            pend_nxt.slot       = cur_r;
            pend_nxt.slot_id    = rd_id_r;
            pend_nxt.slot_score = rd_score_r;
            pend_nxt.action     = tns_pkg::ACT_EMPTY;
            pend_nxt.list_size  = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
            pend_nxt.cutoff     = cutoff_r;
            pend_nxt.last       = 1'b0;
          end
        end
        if (advance) begin
          if (scan_last) begin
            state_nxt = ST_FIN;
          end else begin
            cur_nxt = cur_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = cur_r + 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
          if (op_r.is_remove) begin
            pend_vld_nxt = 1'b0;
            if (pend_vld_r) begin
              out_nxt      = pend_r;
              out_nxt.last = 1'b1;
            end else begin
              out_nxt = none_res;
            end
          end else begin
            cnt_nxt    = ins_cnt;
            cutoff_nxt = ins_cutoff;
            if (have_tgt) begin
              wr_en              = 1'b1;
              valid_nxt[tgt]     = 1'b1;
              out_nxt.slot       = tgt;
              out_nxt.slot_id    = op_r.id;
              out_nxt.slot_score = op_r.score;
              out_nxt.action     = tns_pkg::ACT_WRITE;
              out_nxt.list_size  = ins_cnt;
              out_nxt.cutoff     = ins_cutoff;
              out_nxt.last       = 1'b1;
            end else begin
              out_nxt           = none_res;
              out_nxt.list_size = ins_cnt;
              out_nxt.cutoff    = ins_cutoff;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cap_r      <= tns_pkg::CAP_RESET;
      valid_r    <= '0;
      cnt_r      <= '0;
      cutoff_r   <= tns_pkg::SCORE_MIN;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      cnt_r      <= cnt_nxt;
      cutoff_r   <= cutoff_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    cur_r       <= cur_nxt;
    empty_fnd_r <= empty_fnd_nxt;
    empty_idx_r <= empty_idx_nxt;
    low_fnd_r   <= low_fnd_nxt;
    low_idx_r   <= low_idx_nxt;
    low_score_r <= low_score_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  // Slot memories: one registered read and one write per cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_id_r    <= id_mem[rd_addr];
      rd_score_r <= score_mem[rd_addr];
    end
    if (wr_en) begin
      id_mem[wr_addr]    <= op_r.id;
      score_mem[wr_addr] <= op_r.score;
    end
  end

`ifndef SYNTH
  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("occupied count differs from number of valid slots");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.action == tns_pkg::ACT_NONE) |-> out_r.last)
    else $error("no-change result without last flag");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_vld_r)
    else $error("pending removal left behind after request finished");

  a_pending_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> op_r.is_remove)
    else $error("pending result during an insert");
`endif

endmodule

FILE: hw/rtl/top_n_shortlist_top.sv
// Top level of the top-n shortlist block: front stage, request queue and
// scan engine. Depends on tns_pkg, tns_front, tns_queue and tns_back.
`timescale 1ns / 1ps

// The shortlist keeps up to 32 ids with Q16.16 scores and a running score
// cutoff. Each input beat is an insert or a remove. An insert is scanned
// over slots 0 to capacity-1, one slot per cycle, and then written back,
// and always gives exactly one result beat. A remove scans all 32 slots,
// one per cycle while the result channel is not stalled, and gives one
// result beat per emptied slot (or a single no-change beat). The single
// read port of the slot memories sets this pace. A two-entry queue behind
// the input register lets up to three requests be taken while one is
// being scanned, and results sit in an output register, so neither side
// waits on the other beat by beat. The last flag marks the final result
// beat of each request. The user must write capacity through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block itself does
// not enforce this. Zero acts as one and values above 32 act as 32.
module top_n_shortlist_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [0:0]             in_opcode,
  input  logic [31:0]            in_item_id,
  input  logic signed [31:0]     in_item_score,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [4:0]             out_slot,
  output logic [31:0]            out_slot_id,
  output logic signed [31:0]     out_slot_score,
  output logic [1:0]             out_action,
  output logic [5:0]             out_list_size,
  output logic signed [31:0]     out_cutoff,
  output logic                   out_last,
  input  logic                   cfg_wr_en,
  input  logic [5:0]             cfg_wr_data
);

  logic             push, q_full, q_vld, pop;
  tns_pkg::item_t   push_item, q_item;
  tns_pkg::result_t res;

  // Input register and opcode decode.
  tns_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_item_id   (in_item_id),
    .in_item_score(in_item_score),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  // Decouples the front from the scan engine.
  tns_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .q_vld    (q_vld),
    .q_item   (q_item),
    .pop      (pop)
  );

  // Slot scan, list update and result generation.
  tns_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_item     (q_item),
    .pop        (pop),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_slot       = res.slot;
  assign out_slot_id    = res.slot_id;
  assign out_slot_score = res.slot_score;
  assign out_action     = res.action;
  assign out_list_size  = res.list_size;
  assign out_cutoff     = res.cutoff;
  assign out_last       = res.last;

endmodule
